@@ hdl/tun_pkg.sv @@
// Package for the triangle unit normal block: widths and beat structs.
// No dependencies.
`timescale 1ns / 1ps
package tun_pkg;
    localparam int COORD_BITS  = 16;
    localparam int FRAC_BITS   = 14;
    localparam int OUT_BITS    = 16;
    localparam int EDGE_BITS   = COORD_BITS + 1;
    localparam int CROSS_BITS  = 2 * EDGE_BITS + 1;
    localparam int MAG_BITS    = 30;
    localparam int SUM_BITS    = 62;
    localparam int ROOT_BITS   = 31;
    localparam int NUM_BITS    = MAG_BITS + FRAC_BITS + 1;
    localparam int QUO_BITS    = FRAC_BITS + 2;
    localparam int SHIFT_BITS  = $clog2(MAG_BITS + 1);

    typedef struct packed {
        logic signed [COORD_BITS-1:0] first_x;
        logic signed [COORD_BITS-1:0] first_y;
        logic signed [COORD_BITS-1:0] first_z;
        logic signed [COORD_BITS-1:0] second_x;
        logic signed [COORD_BITS-1:0] second_y;
        logic signed [COORD_BITS-1:0] second_z;
        logic signed [COORD_BITS-1:0] third_x;
        logic signed [COORD_BITS-1:0] third_y;
        logic signed [COORD_BITS-1:0] third_z;
    } tri_in_t;

    typedef struct packed {
        logic signed [OUT_BITS-1:0] normal_x;
        logic signed [OUT_BITS-1:0] normal_y;
        logic signed [OUT_BITS-1:0] normal_z;
        logic                       degenerate;
    } tri_out_t;

    typedef struct packed {
        logic [2:0]              neg;
        logic [2:0][MAG_BITS-1:0] mag;
        logic                    degen;
    } norm_vec_t;
endpackage

@@ hdl/triangle_unit_normal.sv @@
// Top level of the triangle unit normal pipeline.
// Depends on tun_pkg, tun_cross, tun_norm.
//  channel | dir | beat       | handshake
//  s_      | in  | tri_in_t   | s_valid/s_ready
//  m_      | out | tri_out_t  | m_valid/m_ready
// One beat per cycle while m_ready does not stall; stages are 3 cross stages, 2 squaring stages,
// 31 root stages, one divide setup stage, 16 quotient stages and one output stage.
// Synchronous active-low reset clears the valid bits only.
// A stall at m_ready holds the whole pipeline; nothing is lost or repeated.
`timescale 1ns / 1ps
module triangle_unit_normal (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  tun_pkg::tri_in_t  s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output tun_pkg::tri_out_t m_data
);
    import tun_pkg::*;

    logic en, mid_valid;
    norm_vec_t mid_data;

    assign en = m_ready || !m_valid;
    assign s_ready = en;

    tun_cross u_cross (
        .aclk(aclk), .aresetn(aresetn), .en(en), .in_valid(s_valid && s_ready),
        .in_data(s_data), .out_valid(mid_valid), .out_data(mid_data)
    );

    tun_norm u_norm (
        .aclk(aclk), .aresetn(aresetn), .en(en), .in_valid(mid_valid),
        .in_data(mid_data), .out_valid(m_valid), .out_data(m_data)
    );

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result beat dropped under stall");
    a_degen: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.degenerate |-> m_data.normal_x == '0 && m_data.normal_y == '0
        && m_data.normal_z == '0)
        else $error("degenerate beat carries a nonzero normal");
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input stalled with empty output");
endmodule

@@ hdl/tun_cross.sv @@
// Cross product front end: edges, cross product, normalization of the largest component to [2^29, 2^30).
// Depends on tun_pkg. Three register stages, stall by shared enable.
`timescale 1ns / 1ps
module tun_cross (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               en,
    input  logic               in_valid,
    input  tun_pkg::tri_in_t   in_data,
    output logic               out_valid,
    output tun_pkg::norm_vec_t out_data
);
    import tun_pkg::*;

    logic signed [EDGE_BITS-1:0] e_reg [6];
    logic signed [2*EDGE_BITS-1:0] p_reg [6];
    logic signed [CROSS_BITS-1:0] c_next [3];
    logic [CROSS_BITS-1:0] m_next [3];
    logic [CROSS_BITS-1:0] mx;
    logic [SHIFT_BITS:0] lead;
    logic [2:0] v_reg;
    norm_vec_t n_reg, n_next;

    always_comb begin
        c_next[0] = CROSS_BITS'(p_reg[0]) - CROSS_BITS'(p_reg[1]);
        c_next[1] = CROSS_BITS'(p_reg[2]) - CROSS_BITS'(p_reg[3]);
        c_next[2] = CROSS_BITS'(p_reg[4]) - CROSS_BITS'(p_reg[5]);
        for (int i = 0; i < 3; i++) begin
            m_next[i] = c_next[i][CROSS_BITS-1] ? CROSS_BITS'(-c_next[i])
                                                : CROSS_BITS'(c_next[i]);
        end
        mx = m_next[0] | m_next[1] | m_next[2];
        lead = '0;
        for (int b = 0; b < CROSS_BITS; b++) begin
            if (mx[b]) lead = (SHIFT_BITS+1)'(b);
        end
        n_next.degen = (mx == '0);
        for (int i = 0; i < 3; i++) begin
            n_next.neg[i] = c_next[i][CROSS_BITS-1];
            if (lead >= (SHIFT_BITS+1)'(MAG_BITS - 1))
                n_next.mag[i] = MAG_BITS'(m_next[i] >> (lead - (SHIFT_BITS+1)'(MAG_BITS-1)));
            else
                n_next.mag[i] = MAG_BITS'(m_next[i] << ((SHIFT_BITS+1)'(MAG_BITS-1) - lead));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (en) begin
            v_reg <= {v_reg[1:0], in_valid};
        end
        if (en) begin
            e_reg[0] <= EDGE_BITS'(in_data.second_x) - EDGE_BITS'(in_data.first_x);
            e_reg[1] <= EDGE_BITS'(in_data.second_y) - EDGE_BITS'(in_data.first_y);
            e_reg[2] <= EDGE_BITS'(in_data.second_z) - EDGE_BITS'(in_data.first_z);
            e_reg[3] <= EDGE_BITS'(in_data.third_x) - EDGE_BITS'(in_data.first_x);
            e_reg[4] <= EDGE_BITS'(in_data.third_y) - EDGE_BITS'(in_data.first_y);
            e_reg[5] <= EDGE_BITS'(in_data.third_z) - EDGE_BITS'(in_data.first_z);
            p_reg[0] <= e_reg[5] * e_reg[1];
            p_reg[1] <= e_reg[4] * e_reg[2];
            p_reg[2] <= e_reg[3] * e_reg[2];
            p_reg[3] <= e_reg[5] * e_reg[0];
            p_reg[4] <= e_reg[4] * e_reg[0];
            p_reg[5] <= e_reg[3] * e_reg[1];
            n_reg <= n_next;
        end
    end

    assign out_valid = v_reg[2];
    assign out_data  = n_reg;
endmodule

@@ hdl/tun_norm.sv @@
// Back end: sum of squares, pipelined square root, pipelined rounded divide, clamp.
// Depends on tun_pkg. One root bit and one quotient bit per stage.
`timescale 1ns / 1ps
module tun_norm (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               en,
    input  logic               in_valid,
    input  tun_pkg::norm_vec_t in_data,
    output logic               out_valid,
    output tun_pkg::tri_out_t  out_data
);
    import tun_pkg::*;

    localparam int SQ_ST  = ROOT_BITS;
    localparam int DV_ST  = QUO_BITS;
    localparam int DEPTH  = 2 + SQ_ST + 1 + DV_ST + 1;

    logic [DEPTH-1:0] v_reg;
    logic [2*MAG_BITS-1:0] sq_reg [3];
    norm_vec_t a_reg;
    logic [SUM_BITS-1:0] s_reg [SQ_ST+1];
    logic [SUM_BITS-1:0] rem_reg [SQ_ST+1];
    logic [ROOT_BITS-1:0] r_reg [SQ_ST+1];
    norm_vec_t sv_reg [SQ_ST+1];
    norm_vec_t dv_reg [DV_ST+1];
    logic [ROOT_BITS-1:0] l_reg [DV_ST+1];
    logic [2:0][NUM_BITS+1:0] nr_reg [DV_ST+1];
    logic [2:0][QUO_BITS-1:0] q_reg [DV_ST+1];
    tri_out_t o_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (en) begin
            v_reg <= {v_reg[DEPTH-2:0], in_valid};
        end
        if (en) begin
            for (int i = 0; i < 3; i++)
                sq_reg[i] <= (2*MAG_BITS)'(in_data.mag[i]) * (2*MAG_BITS)'(in_data.mag[i]);
            a_reg <= in_data;
            s_reg[0] <= SUM_BITS'(sq_reg[0]) + SUM_BITS'(sq_reg[1]) + SUM_BITS'(sq_reg[2]);
            rem_reg[0] <= '0;
            r_reg[0] <= '0;
            sv_reg[0] <= a_reg;
            for (int k = 0; k < SQ_ST; k++) begin : sq
                logic [SUM_BITS-1:0] rem;
                logic [SUM_BITS-1:0] trial;
                rem = {rem_reg[k][SUM_BITS-3:0], s_reg[k][SUM_BITS-1:SUM_BITS-2]};
                trial = (SUM_BITS'(r_reg[k]) << 2) | SUM_BITS'(1);
                if (rem >= trial) begin
                    rem_reg[k+1] <= rem - trial;
                    r_reg[k+1] <= {r_reg[k][ROOT_BITS-2:0], 1'b1};
                end else begin
                    rem_reg[k+1] <= rem;
                    r_reg[k+1] <= {r_reg[k][ROOT_BITS-2:0], 1'b0};
                end
                s_reg[k+1] <= s_reg[k] << 2;
                sv_reg[k+1] <= sv_reg[k];
            end
            l_reg[0] <= r_reg[SQ_ST];
            dv_reg[0] <= sv_reg[SQ_ST];
            for (int i = 0; i < 3; i++) begin
                nr_reg[0][i] <= (NUM_BITS+2)'({sv_reg[SQ_ST].mag[i], FRAC_BITS'(0)})
                              + (NUM_BITS+2)'(r_reg[SQ_ST] >> 1);
                q_reg[0][i] <= '0;
            end
            for (int k = 0; k < DV_ST; k++) begin : dv
                logic [NUM_BITS+1:0] d;
                d = (NUM_BITS+2)'(l_reg[k]) << (DV_ST - 1 - k);
                for (int i = 0; i < 3; i++) begin
                    if (nr_reg[k][i] >= d) begin
                        nr_reg[k+1][i] <= nr_reg[k][i] - d;
                        q_reg[k+1][i] <= q_reg[k][i] | (QUO_BITS'(1) << (DV_ST - 1 - k));
                    end else begin
                        nr_reg[k+1][i] <= nr_reg[k][i];
                        q_reg[k+1][i] <= q_reg[k][i];
                    end
                end
                l_reg[k+1] <= l_reg[k];
                dv_reg[k+1] <= dv_reg[k];
            end
            begin : fin
                logic [QUO_BITS-1:0] q [3];
                logic [OUT_BITS-1:0] r [3];
                for (int i = 0; i < 3; i++) begin
                    q[i] = q_reg[DV_ST][i];
                    if (q[i] > QUO_BITS'(1 << FRAC_BITS)) q[i] = QUO_BITS'(1 << FRAC_BITS);
                    r[i] = dv_reg[DV_ST].neg[i] ? OUT_BITS'(-q[i]) : OUT_BITS'(q[i]);
                    if (dv_reg[DV_ST].degen) r[i] = '0;
                end
                o_reg.normal_x <= r[0];
                o_reg.normal_y <= r[1];
                o_reg.normal_z <= r[2];
                o_reg.degenerate <= dv_reg[DV_ST].degen;
            end
        end
    end

    assign out_valid = v_reg[DEPTH-1];
    assign out_data  = o_reg;
endmodule
